// ===== design/lcr_pkg.sv =====
// Shared types and constants for the life-like cell row update unit.
// Used by lcr_evolve and life_like_cell_row_update_unit; no dependencies.
package lcr_pkg;

   localparam int CELLS_W     = 64;  // width of a row word on the ports
   localparam int SIZE_W      = 7;   // board size register width
   localparam int ROW_W       = 6;   // row index width
   localparam int RULE_W      = 4;   // rule threshold width
   localparam int CNT_NB_W    = 4;   // neighbor count width (0..8)
   localparam int DEF_MAX_SIZE = 64;

   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 7;

   localparam logic [CSR_IDX_W-1:0] CSR_BOARD_SIZE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_UNDERPOP_END  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OVERPOP_START = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BIRTH_START   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BIRTH_END     = 3'd4;

   localparam logic [SIZE_W-1:0] RST_BOARD_SIZE    = 7'd64;
   localparam logic [RULE_W-1:0] RST_UNDERPOP_END  = 4'd1;
   localparam logic [RULE_W-1:0] RST_OVERPOP_START = 4'd4;
   localparam logic [RULE_W-1:0] RST_BIRTH_START   = 4'd3;
   localparam logic [RULE_W-1:0] RST_BIRTH_END     = 4'd3;

   // result queue between the update logic and the result port
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   typedef struct packed {
      logic [RULE_W-1:0] underpop_end;
      logic [RULE_W-1:0] overpop_start;
      logic [RULE_W-1:0] birth_start;
      logic [RULE_W-1:0] birth_end;
   } lcr_rules_type;

endpackage

// ===== design/lcr_evolve.sv =====
// Next generation of one board row from the rows above, at and below it.
// Depends on lcr_pkg for the rule struct and count widths.
module lcr_evolve
   import lcr_pkg::*;
#(
   parameter int WIDTH = DEF_MAX_SIZE
) (
   input  logic [WIDTH-1:0] up,
   input  logic [WIDTH-1:0] mid,
   input  logic [WIDTH-1:0] down,
   input  logic [WIDTH-1:0] mask,
   input  lcr_rules_type    rules,
   output logic [WIDTH-1:0] next_row
);

   logic [WIDTH+1:0] up_x;
   logic [WIDTH+1:0] mid_x;
   logic [WIDTH+1:0] down_x;

   // pad with a dead cell on each side so column edges need no special case
   assign up_x   = {1'b0, up, 1'b0};
   assign mid_x  = {1'b0, mid, 1'b0};
   assign down_x = {1'b0, down, 1'b0};

   always_comb begin
      logic [CNT_NB_W-1:0] cnt;
      logic                nxt;
      next_row = '0;
      for (int c = 0; c < WIDTH; c++) begin
         cnt = CNT_NB_W'(up_x[c]) + CNT_NB_W'(up_x[c+1]) + CNT_NB_W'(up_x[c+2])
             + CNT_NB_W'(mid_x[c]) + CNT_NB_W'(mid_x[c+2])
             + CNT_NB_W'(down_x[c]) + CNT_NB_W'(down_x[c+1]) + CNT_NB_W'(down_x[c+2]);
         if (cnt <= rules.underpop_end) begin
            nxt = 1'b0;
         end else if (cnt >= rules.overpop_start) begin
            nxt = 1'b0;
         end else if (cnt >= rules.birth_start && cnt <= rules.birth_end) begin
            nxt = 1'b1;
         end else begin
            nxt = mid[c];
         end
         next_row[c] = nxt & mask[c];
      end
   end

endmodule

// ===== design/life_like_cell_row_update_unit.sv =====
// Life-like cell row update unit: one board row per accepted word.
// Results enter the queue as the row completing them is accepted. Throughput:
// one row per cycle; a multi-row board's final row gives two results, drained
// one per cycle while rsp_stall is low from a four-entry result queue (stall
// while fewer than two entries are free). Reset clears rows, row count, queue
// and restores the rule registers to defaults. Depends on lcr_pkg, lcr_evolve.
module life_like_cell_row_update_unit
   import lcr_pkg::*;
#(
   parameter int MAX_SIZE = DEF_MAX_SIZE
) (
   input  logic                  clock,
   input  logic                  reset,
   // input rows
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [CELLS_W-1:0]    req_row_cells,
   // results
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [CELLS_W-1:0]    rsp_next_cells,
   output logic [ROW_W-1:0]      rsp_row_number,
   output logic                  rsp_last_row,
   // configuration
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   logic [SIZE_W-1:0]   board_size_ff;
   lcr_rules_type       rules_ff;

   logic [MAX_SIZE-1:0] above_ff, above_in;
   logic [MAX_SIZE-1:0] pending_ff, pending_in;
   logic [ROW_W-1:0]    rows_ff, rows_in;

   logic [MAX_SIZE-1:0] q_cells_ff [QUEUE_DEPTH];
   logic [ROW_W-1:0]    q_row_ff   [QUEUE_DEPTH];
   logic                q_last_ff  [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic [QPTR_W-1:0]   wr_ptr_b;

   logic [SIZE_W-1:0]   n_size;
   logic [MAX_SIZE-1:0] mask;
   logic [MAX_SIZE-1:0] row_in;
   logic [MAX_SIZE-1:0] above_m;
   logic [MAX_SIZE-1:0] pending_m;
   logic [MAX_SIZE-1:0] up_b;
   logic [MAX_SIZE-1:0] cells_a;
   logic [MAX_SIZE-1:0] cells_b;
   logic                accept;
   logic                first;
   logic                last;
   logic                push_a;
   logic                push_b;
   logic                pop;

   // ---------------- configuration ----------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         board_size_ff          <= RST_BOARD_SIZE;
         rules_ff.underpop_end  <= RST_UNDERPOP_END;
         rules_ff.overpop_start <= RST_OVERPOP_START;
         rules_ff.birth_start   <= RST_BIRTH_START;
         rules_ff.birth_end     <= RST_BIRTH_END;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BOARD_SIZE:    board_size_ff          <= csr_data[SIZE_W-1:0];
            CSR_UNDERPOP_END:  rules_ff.underpop_end  <= csr_data[RULE_W-1:0];
            CSR_OVERPOP_START: rules_ff.overpop_start <= csr_data[RULE_W-1:0];
            CSR_BIRTH_START:   rules_ff.birth_start   <= csr_data[RULE_W-1:0];
            CSR_BIRTH_END:     rules_ff.birth_end     <= csr_data[RULE_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp the board size into 1..MAX_SIZE
   always_comb begin
      if (board_size_ff == '0) begin
         n_size = SIZE_W'(1);
      end else if (board_size_ff > SIZE_W'(MAX_SIZE)) begin
         n_size = SIZE_W'(MAX_SIZE);
      end else begin
         n_size = board_size_ff;
      end
   end

   always_comb begin
      for (int c = 0; c < MAX_SIZE; c++) begin
         mask[c] = (SIZE_W'(c) < n_size);
      end
   end

   // ---------------- row update ----------------
   assign accept = req_valid && !req_stall;
   assign first  = (rows_ff == '0);
   assign last   = ({1'b0, rows_ff} + SIZE_W'(1)) >= n_size;
   assign push_a = accept && !first;
   assign push_b = accept && last;

   assign row_in    = req_row_cells[MAX_SIZE-1:0] & mask;
   assign above_m   = above_ff & mask;
   assign pending_m = pending_ff & mask;
   assign up_b      = first ? '0 : pending_m;

   lcr_evolve #(.WIDTH(MAX_SIZE)) u_evolve_a (
      .up       (above_m),
      .mid      (pending_m),
      .down     (row_in),
      .mask     (mask),
      .rules    (rules_ff),
      .next_row (cells_a)
   );

   // final row: the row below the board is dead
   lcr_evolve #(.WIDTH(MAX_SIZE)) u_evolve_b (
      .up       (up_b),
      .mid      (row_in),
      .down     ('0),
      .mask     (mask),
      .rules    (rules_ff),
      .next_row (cells_b)
   );

   always_comb begin
      above_in   = above_ff;
      pending_in = pending_ff;
      rows_in    = rows_ff;
      if (accept) begin
         if (last) begin
            above_in   = '0;
            pending_in = '0;
            rows_in    = '0;
         end else begin
            above_in   = first ? '0 : pending_ff;
            pending_in = row_in;
            rows_in    = rows_ff + ROW_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         above_ff   <= '0;
         pending_ff <= '0;
         rows_ff    <= '0;
      end else begin
         above_ff   <= above_in;
         pending_ff <= pending_in;
         rows_ff    <= rows_in;
      end
   end

   // ---------------- result queue ----------------
   assign pop       = rsp_valid && !rsp_stall;
   assign wr_ptr_b  = wr_ptr_ff + QPTR_W'(push_a);
   assign wr_ptr_in = wr_ptr_ff + QPTR_W'(push_a) + QPTR_W'(push_b);
   assign rd_ptr_in = rd_ptr_ff + QPTR_W'(pop);
   assign count_in  = count_ff + QCNT_W'(push_a) + QCNT_W'(push_b) - QCNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (push_a && wr_ptr_ff == QPTR_W'(i)) begin
            q_cells_ff[i] <= cells_a;
            q_row_ff[i]   <= rows_ff - ROW_W'(1);
            q_last_ff[i]  <= 1'b0;
         end else if (push_b && wr_ptr_b == QPTR_W'(i)) begin
            q_cells_ff[i] <= cells_b;
            q_row_ff[i]   <= rows_ff;
            q_last_ff[i]  <= 1'b1;
         end
      end
   end

   // hold off input until two entries are free
   assign req_stall      = count_ff > QCNT_W'(QUEUE_DEPTH - 2);
   assign rsp_valid      = (count_ff != '0);
   assign rsp_next_cells = CELLS_W'(q_cells_ff[rd_ptr_ff]);
   assign rsp_row_number = q_row_ff[rd_ptr_ff];
   assign rsp_last_row   = q_last_ff[rd_ptr_ff];

`ifndef SYNTHESIS
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("result queue overflow");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && last) |=> (rows_ff == '0 && pending_ff == '0 && above_ff == '0))
      else $error("row state not cleared after final row");

   a_final_offered: assert property (@(posedge clock) disable iff (reset)
      push_b |=> rsp_valid)
      else $error("final row result not offered");
`endif

endmodule
